@@ rtl/core/vrt_pkg.sv @@
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared types and constants for the voxel ray traversal block.
// ----------------------------------------------------------------------------
package vrt_pkg;

    // voxels per chunk edge (power of two)
    localparam int CHUNK_SHIFT = 4;
    localparam int CHUNK_EDGE  = 1 << CHUNK_SHIFT;

    localparam logic [31:0] DSAT = 32'hFFFF_FFFF;

    // result status codes
    localparam logic [1:0] ST_QUERY = 2'd0;
    localparam logic [1:0] ST_HIT   = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;
    localparam logic [1:0] ST_NOREQ = 2'd3;

    // request opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_REPLY = 1'b1;

    // register indexes
    localparam logic [2:0] REG_ORG_X  = 3'd0;
    localparam logic [2:0] REG_ORG_Y  = 3'd1;
    localparam logic [2:0] REG_ORG_Z  = 3'd2;
    localparam logic [2:0] REG_SIZE_X = 3'd3;
    localparam logic [2:0] REG_SIZE_Y = 3'd4;
    localparam logic [2:0] REG_SIZE_Z = 3'd5;

    typedef struct packed {
        logic [2:0][15:0] org;
        logic [2:0][5:0]  size;
    } cfg_t;

    typedef struct packed {
        logic       load;       // latch start request, square directions
        logic       sum;        // sum of squares, start root
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       bound;
        logic       step;
        logic       out_load;
        logic [1:0] kind;
    } cmd_t;

    typedef struct packed {
        logic in_window;
        logic over_reach;
        logic exhausted;
        logic out_free;
    } stat_t;

endpackage

@@ rtl/core/voxel_ray_traversal.sv @@
// ----------------------------------------------------------------------------
// voxel_ray_traversal
// Steps a ray through a voxel grid one voxel at a time and asks for the
// opacity of each voxel that lies inside the loaded chunk window.
//
// Request channel (s_*): op 0 starts a ray, op 1 answers the last query.
// Result channel (s_* -> m_*): exactly one result per request: a voxel
// query, a hit, a miss, or a reply-without-query notice.
// A start runs setup (a bit-serial square root, then three divide lanes
// run in parallel), then steps voxel by voxel, outside-window voxels
// included, and loads its result into the result register. A reply steps
// on the same way, or is emitted without stepping for a hit and for a
// reply with no query pending.
// One request is worked at a time; s_ready is high while the sequencer is
// idle, even if a result still sits in the output register.
// When m_ready is low the finished result is held and the sequencer waits.
// Reset clears the sequencer, drops any ray in flight and loads the window
// registers with origin 0 and size 8 chunks per axis.
// ----------------------------------------------------------------------------
module voxel_ray_traversal import vrt_pkg::*; #(
    parameter int MAX_WINDOW_CHUNKS = 32,
    parameter int MAX_STEPS         = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [4:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic signed [31:0] s_ray_start_x,
    input  logic signed [31:0] s_ray_start_y,
    input  logic signed [31:0] s_ray_start_z,
    input  logic signed [15:0] s_dir_x,
    input  logic signed [15:0] s_dir_y,
    input  logic signed [15:0] s_dir_z,
    input  logic        [23:0] s_reach,
    input  logic               s_is_opaque,
    output logic               m_valid,
    input  logic               m_ready,
    output logic        [1:0]  m_status,
    output logic signed [23:0] m_voxel_x,
    output logic signed [23:0] m_voxel_y,
    output logic signed [23:0] m_voxel_z,
    output logic        [14:0] m_chunk_index,
    output logic        [3:0]  m_in_chunk_x,
    output logic        [3:0]  m_in_chunk_y,
    output logic        [3:0]  m_in_chunk_z,
    output logic        [2:0]  m_face
);

    cfg_t       cfg_reg;
    cmd_t       cmd;
    stat_t      stat;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.org  <= '0;
            cfg_reg.size <= {3{6'd8}};
        end else if (wr_en) begin
            case (reg_idx)
                REG_ORG_X:  cfg_reg.org[0]  <= pwdata[15:0];
                REG_ORG_Y:  cfg_reg.org[1]  <= pwdata[15:0];
                REG_ORG_Z:  cfg_reg.org[2]  <= pwdata[15:0];
                REG_SIZE_X: cfg_reg.size[0] <= pwdata[5:0];
                REG_SIZE_Y: cfg_reg.size[1] <= pwdata[5:0];
                REG_SIZE_Z: cfg_reg.size[2] <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ORG_X:  prdata = {16'b0, cfg_reg.org[0]};
            REG_ORG_Y:  prdata = {16'b0, cfg_reg.org[1]};
            REG_ORG_Z:  prdata = {16'b0, cfg_reg.org[2]};
            REG_SIZE_X: prdata = {26'b0, cfg_reg.size[0]};
            REG_SIZE_Y: prdata = {26'b0, cfg_reg.size[1]};
            REG_SIZE_Z: prdata = {26'b0, cfg_reg.size[2]};
            default:    prdata = '0;
        endcase
    end

    vrt_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_is_opaque (s_is_opaque),
        .cmd         (cmd),
        .stat        (stat)
    );

    vrt_datapath #(
        .MAX_WINDOW_CHUNKS (MAX_WINDOW_CHUNKS),
        .MAX_STEPS         (MAX_STEPS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .cfg           (cfg_reg),
        .s_ray_start_x (s_ray_start_x),
        .s_ray_start_y (s_ray_start_y),
        .s_ray_start_z (s_ray_start_z),
        .s_dir_x       (s_dir_x),
        .s_dir_y       (s_dir_y),
        .s_dir_z       (s_dir_z),
        .s_reach       (s_reach),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_voxel_x     (m_voxel_x),
        .m_voxel_y     (m_voxel_y),
        .m_voxel_z     (m_voxel_z),
        .m_chunk_index (m_chunk_index),
        .m_in_chunk_x  (m_in_chunk_x),
        .m_in_chunk_y  (m_in_chunk_y),
        .m_in_chunk_z  (m_in_chunk_z),
        .m_face        (m_face)
    );

endmodule

@@ rtl/core/vrt_ctrl.sv @@
// ----------------------------------------------------------------------------
// vrt_ctrl
// Sequencer: setup (root, divides, boundaries), stepping loop, result hand-off.
// ----------------------------------------------------------------------------
module vrt_ctrl import vrt_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  logic  s_op,
    input  logic  s_is_opaque,
    output cmd_t  cmd,
    input  stat_t stat
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SUM   = 9'b000000010,
        S_SQRT  = 9'b000000100,
        S_DIVI  = 9'b000001000,
        S_DIV   = 9'b000010000,
        S_BOUND = 9'b000100000,
        S_STEP  = 9'b001000000,
        S_CHECK = 9'b010000000,
        S_EMIT  = 9'b100000000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       busy_reg, busy_next;
    logic [1:0] kind_reg, kind_next;
    logic       accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.kind   = kind_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_op == OP_START) begin
                        cmd.load   = 1'b1;
                        busy_next  = 1'b1;
                        state_next = S_SUM;
                    end else if (!busy_reg) begin
                        kind_next  = ST_NOREQ;
                        state_next = S_EMIT;
                    end else if (s_is_opaque) begin
                        kind_next  = ST_HIT;
                        busy_next  = 1'b0;
                        state_next = S_EMIT;
                    end else begin
                        state_next = S_STEP;
                    end
                end
            end
            S_SUM: begin
                cmd.sum    = 1'b1;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) state_next = S_DIVI;
            end
            S_DIVI: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) state_next = S_BOUND;
            end
            S_BOUND: begin
                cmd.bound  = 1'b1;
                state_next = S_STEP;
            end
            S_STEP: begin
                if (stat.exhausted) begin
                    kind_next  = ST_MISS;
                    busy_next  = 1'b0;
                    state_next = S_EMIT;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.over_reach) begin
                    kind_next  = ST_MISS;
                    busy_next  = 1'b0;
                    state_next = S_EMIT;
                end else if (stat.in_window) begin
                    kind_next  = ST_QUERY;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_STEP;
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            kind_reg  <= ST_QUERY;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            busy_reg  <= busy_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

@@ rtl/core/vrt_datapath.sv @@
// ----------------------------------------------------------------------------
// vrt_datapath
// Ray state, bit-serial root and divide lanes, DDA step, window lookup and
// the result register.
// ----------------------------------------------------------------------------
module vrt_datapath import vrt_pkg::*; #(
    parameter int MAX_WINDOW_CHUNKS = 32,
    parameter int MAX_STEPS         = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    output stat_t              stat,
    input  cfg_t               cfg,
    input  logic signed [31:0] s_ray_start_x,
    input  logic signed [31:0] s_ray_start_y,
    input  logic signed [31:0] s_ray_start_z,
    input  logic signed [15:0] s_dir_x,
    input  logic signed [15:0] s_dir_y,
    input  logic signed [15:0] s_dir_z,
    input  logic        [23:0] s_reach,
    output logic               m_valid,
    input  logic               m_ready,
    output logic        [1:0]  m_status,
    output logic signed [23:0] m_voxel_x,
    output logic signed [23:0] m_voxel_y,
    output logic signed [23:0] m_voxel_z,
    output logic        [14:0] m_chunk_index,
    output logic        [3:0]  m_in_chunk_x,
    output logic        [3:0]  m_in_chunk_y,
    output logic        [3:0]  m_in_chunk_z,
    output logic        [2:0]  m_face
);

    localparam int SW = $clog2(MAX_STEPS + 1);
    localparam logic [6:0]    MAX_SZ   = 7'(MAX_WINDOW_CHUNKS);
    localparam logic [SW-1:0] STEP_LIM = SW'(MAX_STEPS);

    logic [2:0][23:0] cell_reg;
    logic [2:0]       sign_reg;
    logic [2:0][7:0]  frac_reg;
    logic [2:0][15:0] ad_reg;
    logic [2:0][30:0] sq_reg;
    logic [2:0][31:0] q_reg;
    logic [2:0][15:0] rem_reg;
    logic [2:0][31:0] bd_reg;
    logic [2:0][31:0] unit_reg;
    logic [63:0]      rad_reg;
    logic [33:0]      sqrem_reg;
    logic [31:0]      root_reg;
    logic [31:0]      travelled_reg;
    logic [23:0]      limit_reg;
    logic [2:0]       face_reg;
    logic [SW-1:0]    steps_reg;
    logic [13:0]      sxy_reg;

    logic [2:0][31:0] start_w;
    logic [2:0][15:0] dir_w;
    logic [2:0][6:0]  size_eff;

    // window lookup
    logic [2:0][24:0] off;
    logic [2:0]       axis_in;
    logic [2:0][5:0]  chunk;
    logic [19:0]      index_w;

    // root step
    logic [35:0] sq_cur, sq_trial;

    // axis choice
    logic [1:0]  axis;
    logic [32:0] bd_sum;

    assign start_w = {s_ray_start_z, s_ray_start_y, s_ray_start_x};
    assign dir_w   = {s_dir_z, s_dir_y, s_dir_x};

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            size_eff[a] = ({1'b0, cfg.size[a]} > MAX_SZ) ? MAX_SZ : {1'b0, cfg.size[a]};
            off[a] = {cell_reg[a][23], cell_reg[a]}
                   - {{5{cfg.org[a][15]}}, cfg.org[a], 4'b0};
            axis_in[a] = !off[a][24]
                       && (off[a] < {14'b0, size_eff[a], CHUNK_SHIFT'(0)});
            chunk[a] = off[a][CHUNK_SHIFT+5:CHUNK_SHIFT];
        end
    end

    assign index_w = 20'(chunk[1]) + 20'(chunk[0]) * 20'(size_eff[1])
                   + 20'(chunk[2]) * 20'(sxy_reg);

    assign sq_cur   = {sqrem_reg, rad_reg[63:62]};
    assign sq_trial = {2'b0, root_reg, 2'b01};

    always_comb begin
        if (bd_reg[0] < bd_reg[1] && bd_reg[0] < bd_reg[2])       axis = 2'd0;
        else if (bd_reg[1] <= bd_reg[0] && bd_reg[1] < bd_reg[2]) axis = 2'd1;
        else                                                      axis = 2'd2;
        bd_sum = {1'b0, bd_reg[axis]} + {1'b0, unit_reg[axis]};
    end

    assign stat.in_window  = &axis_in;
    assign stat.over_reach = travelled_reg > {limit_reg, 8'b0};
    assign stat.exhausted  = steps_reg >= STEP_LIM;
    assign stat.out_free   = !m_valid || m_ready;

    always_ff @(posedge aclk) begin
        sxy_reg <= size_eff[0] * size_eff[1];

        if (cmd.load) begin
            for (int a = 0; a < 3; a++) begin
                cell_reg[a] <= start_w[a][31:8];
                frac_reg[a] <= start_w[a][7:0];
                sign_reg[a] <= dir_w[a][15];
                ad_reg[a]   <= dir_w[a][15] ? 16'(-dir_w[a]) : dir_w[a];
                // low bits of the 32-bit product equal the signed square
                sq_reg[a]   <= 31'({{16{dir_w[a][15]}}, dir_w[a]}
                                 * {{16{dir_w[a][15]}}, dir_w[a]});
            end
            limit_reg     <= s_reach;
            travelled_reg <= '0;
            steps_reg     <= '0;
            face_reg      <= '0;
        end

        if (cmd.sum) begin
            rad_reg   <= {32'(sq_reg[0]) + 32'(sq_reg[1]) + 32'(sq_reg[2]), 32'b0};
            sqrem_reg <= '0;
            root_reg  <= '0;
        end

        if (cmd.sqrt_step) begin
            rad_reg <= {rad_reg[61:0], 2'b00};
            if (sq_cur >= sq_trial) begin
                sqrem_reg <= 34'(sq_cur - sq_trial);
                root_reg  <= {root_reg[30:0], 1'b1};
            end else begin
                sqrem_reg <= sq_cur[33:0];
                root_reg  <= {root_reg[30:0], 1'b0};
            end
        end

        if (cmd.div_init) begin
            for (int a = 0; a < 3; a++) begin
                q_reg[a]   <= root_reg;
                rem_reg[a] <= '0;
            end
        end

        if (cmd.div_step) begin
            for (int a = 0; a < 3; a++) begin
                if ({rem_reg[a], q_reg[a][31]} >= {1'b0, ad_reg[a]}) begin
                    rem_reg[a] <= 16'({rem_reg[a], q_reg[a][31]} - {1'b0, ad_reg[a]});
                    q_reg[a]   <= {q_reg[a][30:0], 1'b1};
                end else begin
                    rem_reg[a] <= {rem_reg[a][14:0], q_reg[a][31]};
                    q_reg[a]   <= {q_reg[a][30:0], 1'b0};
                end
            end
        end

        if (cmd.bound) begin
            for (int a = 0; a < 3; a++) begin
                logic [8:0]  fd;
                logic [40:0] prod;
                fd   = sign_reg[a] ? {1'b0, frac_reg[a]} : 9'd256 - {1'b0, frac_reg[a]};
                prod = {32'b0, fd} * {9'b0, q_reg[a]};
                if (ad_reg[a] == 16'd0) begin
                    unit_reg[a] <= DSAT;
                    bd_reg[a]   <= DSAT;
                end else begin
                    unit_reg[a] <= q_reg[a];
                    bd_reg[a]   <= prod[40] ? DSAT : prod[39:8];
                end
            end
        end

        if (cmd.step) begin
            cell_reg[axis] <= cell_reg[axis] + (sign_reg[axis] ? 24'hFF_FFFF : 24'd1);
            travelled_reg  <= bd_reg[axis];
            bd_reg[axis]   <= bd_sum[32] ? DSAT : bd_sum[31:0];
            face_reg       <= {axis, !sign_reg[axis]};
            steps_reg      <= steps_reg + SW'(1);
        end

        if (cmd.out_load) begin
            m_status <= cmd.kind;
            if (cmd.kind == ST_QUERY || (cmd.kind == ST_HIT && stat.in_window)) begin
                m_voxel_x     <= cell_reg[0];
                m_voxel_y     <= cell_reg[1];
                m_voxel_z     <= cell_reg[2];
                m_chunk_index <= index_w[14:0];
                m_in_chunk_x  <= off[0][3:0];
                m_in_chunk_y  <= off[1][3:0];
                m_in_chunk_z  <= off[2][3:0];
                m_face        <= face_reg;
            end else begin
                m_voxel_x     <= '0;
                m_voxel_y     <= '0;
                m_voxel_z     <= '0;
                m_chunk_index <= '0;
                m_in_chunk_x  <= '0;
                m_in_chunk_y  <= '0;
                m_in_chunk_z  <= '0;
                m_face        <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

endmodule

@@ tb/voxel_ray_traversal_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ray_traversal_test
// Self-checking bench for the voxel ray traversal block: directed rays and
// replies, then random ray walks under several window settings and idle mixes.
// Every result is checked field by field against an in-bench DDA tracer.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_test;
    import vrt_pkg::*;

    localparam int MAX_WIN   = 32;
    localparam int MAX_STEPS = 1024;
    localparam longint CYCLE_LIMIT = 10_000_000;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] vx, vy, vz;
        logic [14:0] chunk;
        logic [3:0]  ix, iy, iz;
        logic [2:0]  face;
    } voxel_res_t;

    typedef struct {
        logic        op;
        logic [31:0] sx, sy, sz;
        logic [15:0] dx, dy, dz;
        logic [23:0] reach;
        logic        opaque;
        bit          typed;
        logic [1:0]  typed_status;
    } request_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op = 1'b0;
    logic signed [31:0] s_ray_start_x = '0, s_ray_start_y = '0, s_ray_start_z = '0;
    logic signed [15:0] s_dir_x = '0, s_dir_y = '0, s_dir_z = '0;
    logic [23:0] s_reach = '0;
    logic        s_is_opaque = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic signed [23:0] m_voxel_x, m_voxel_y, m_voxel_z;
    logic [14:0] m_chunk_index;
    logic [3:0]  m_in_chunk_x, m_in_chunk_y, m_in_chunk_z;
    logic [2:0]  m_face;

    voxel_ray_traversal #(.MAX_WINDOW_CHUNKS(MAX_WIN), .MAX_STEPS(MAX_STEPS)) DUT (.*);

    always #6 aclk = ~aclk;

    // tracer state
    logic [15:0] win_org [3];
    logic [5:0]  win_size [3];
    bit          ray_busy;
    logic [23:0] vox_pos [3];
    bit          neg_step [3];
    logic [31:0] bound_d [3];
    logic [31:0] unit_d [3];
    logic [31:0] travelled;
    logic [23:0] reach_lim;
    logic [2:0]  last_face;
    int          steps;

    voxel_res_t expected_q [$];
    int     errors = 0;
    int     n_query = 0, n_hit = 0, n_miss = 0, n_noreq = 0, n_req = 0;
    int     send_idle = 0, recv_stall = 0;
    longint cycles = 0;

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint eff_size(int a);
        return (win_size[a] > MAX_WIN) ? MAX_WIN : win_size[a];
    endfunction

    function automatic bit locate(output voxel_res_t r);
        longint off [3];
        longint base;
        r = '0;
        for (int a = 0; a < 3; a++) begin
            base = longint'($signed(win_org[a])) * CHUNK_EDGE;
            off[a] = longint'($signed(vox_pos[a])) - base;
            if (off[a] < 0 || off[a] >= eff_size(a) * CHUNK_EDGE) return 0;
        end
        r.status = ST_QUERY;
        r.vx = vox_pos[0];
        r.vy = vox_pos[1];
        r.vz = vox_pos[2];
        r.chunk = 15'(off[1] / CHUNK_EDGE + (off[0] / CHUNK_EDGE) * eff_size(1)
                  + (off[2] / CHUNK_EDGE) * eff_size(0) * eff_size(1));
        r.ix = 4'(off[0] % CHUNK_EDGE);
        r.iy = 4'(off[1] % CHUNK_EDGE);
        r.iz = 4'(off[2] % CHUNK_EDGE);
        r.face = last_face;
        return 1;
    endfunction

    function automatic voxel_res_t step_ray();
        voxel_res_t r;
        int a;
        logic [32:0] nb;
        r = '0;
        while (1) begin
            if (steps >= MAX_STEPS) begin
                ray_busy = 0;
                r = '0;
                r.status = ST_MISS;
                return r;
            end
            if (bound_d[0] < bound_d[1] && bound_d[0] < bound_d[2]) a = 0;
            else if (bound_d[1] <= bound_d[0] && bound_d[1] < bound_d[2]) a = 1;
            else a = 2;
            vox_pos[a] = neg_step[a] ? vox_pos[a] - 24'd1 : vox_pos[a] + 24'd1;
            travelled = bound_d[a];
            nb = {1'b0, bound_d[a]} + unit_d[a];
            bound_d[a] = nb[32] ? DSAT : nb[31:0];
            last_face = 3'(2 * a + (neg_step[a] ? 0 : 1));
            steps++;
            if ({32'd0, travelled} > ({40'd0, reach_lim} << 8)) begin
                ray_busy = 0;
                r = '0;
                r.status = ST_MISS;
                return r;
            end
            if (locate(r)) return r;
        end
    endfunction

    function automatic voxel_res_t trace_request(request_t q);
        voxel_res_t r;
        longint d [3];
        logic [63:0] sumsq, mag, ad, unit, fd, bd;
        logic [31:0] raw [3];
        r = '0;
        raw[0] = q.sx;
        raw[1] = q.sy;
        raw[2] = q.sz;
        if (q.op == OP_START) begin
            d[0] = $signed(q.dx);
            d[1] = $signed(q.dy);
            d[2] = $signed(q.dz);
            sumsq = 0;
            for (int a = 0; a < 3; a++) sumsq += 64'(d[a] * d[a]);
            mag = root64(sumsq << 32);
            for (int a = 0; a < 3; a++) begin
                vox_pos[a] = raw[a][31:8];
                neg_step[a] = d[a] < 0;
                ad = 64'(d[a] < 0 ? -d[a] : d[a]);
                if (ad == 0) begin
                    unit_d[a] = DSAT;
                    bound_d[a] = DSAT;
                end else begin
                    unit = mag / ad;
                    if (unit > DSAT) unit = DSAT;
                    unit_d[a] = unit[31:0];
                    fd = neg_step[a] ? raw[a][7:0] : 64'd256 - raw[a][7:0];
                    bd = (fd * unit) >> 8;
                    bound_d[a] = (bd > DSAT) ? DSAT : bd[31:0];
                end
            end
            reach_lim = q.reach;
            travelled = 0;
            steps = 0;
            last_face = 0;
            ray_busy = 1;
            return step_ray();
        end
        if (!ray_busy) begin
            r.status = ST_NOREQ;
            return r;
        end
        if (q.opaque) begin
            if (!locate(r)) r = '0;
            r.status = ST_HIT;
            ray_busy = 0;
            return r;
        end
        return step_ray();
    endfunction

    task automatic send_request(request_t q);
        voxel_res_t r;
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_op <= q.op;
        s_ray_start_x <= q.sx;
        s_ray_start_y <= q.sy;
        s_ray_start_z <= q.sz;
        s_dir_x <= q.dx;
        s_dir_y <= q.dy;
        s_dir_z <= q.dz;
        s_reach <= q.reach;
        s_is_opaque <= q.opaque;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        r = trace_request(q);
        if (q.typed && r.status !== q.typed_status) begin
            $error("typed status: expected %0d, tracer %0d", q.typed_status, r.status);
            errors++;
        end
        expected_q.push_back(r);
        n_req++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx <= REG_ORG_Z) win_org[idx] = value[15:0];
        else win_size[idx - REG_SIZE_X] = value[5:0];
    endtask

    task automatic set_window(logic [15:0] ox, logic [15:0] oy, logic [15:0] oz,
                              logic [5:0] wx, logic [5:0] wy, logic [5:0] wz);
        reg_write(REG_ORG_X, {16'd0, ox});
        reg_write(REG_ORG_Y, {16'd0, oy});
        reg_write(REG_ORG_Z, {16'd0, oz});
        reg_write(REG_SIZE_X, {26'd0, wx});
        reg_write(REG_SIZE_Y, {26'd0, wy});
        reg_write(REG_SIZE_Z, {26'd0, wz});
        @(posedge aclk);
    endtask

    function automatic request_t mk(logic op, logic [31:0] sx, logic [31:0] sy,
                                    logic [31:0] sz, logic [15:0] dx, logic [15:0] dy,
                                    logic [15:0] dz, logic [23:0] reach, logic opq);
        request_t q;
        q.op = op;
        q.sx = sx;
        q.sy = sy;
        q.sz = sz;
        q.dx = dx;
        q.dy = dy;
        q.dz = dz;
        q.reach = reach;
        q.opaque = opq;
        q.typed = 0;
        q.typed_status = ST_QUERY;
        return q;
    endfunction

    function automatic request_t random_request();
        request_t q;
        longint span, base;
        logic [23:0] c;
        logic [31:0] raw [3];
        q = mk(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, 16'($urandom),
               16'($urandom), 16'($urandom), 24'($urandom), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 99) < 10) return q;         // noise
        if (ray_busy && $urandom_range(0, 99) < 95) begin
            q.op = OP_REPLY;
            q.opaque = $urandom_range(0, 99) < 15;
            return q;
        end
        q.op = OP_START;
        for (int a = 0; a < 3; a++) begin
            span = eff_size(a) * CHUNK_EDGE;
            base = longint'($signed(win_org[a])) * CHUNK_EDGE;
            c = (span == 0) ? 24'($urandom) : 24'(base + $urandom_range(0, span - 1));
            raw[a] = {c, 8'($urandom)};
        end
        q.sx = raw[0];
        q.sy = raw[1];
        q.sz = raw[2];
        if ($urandom_range(0, 9) == 0) q.dx = 0;
        if ($urandom_range(0, 9) == 0) q.dy = 0;
        if ($urandom_range(0, 9) == 0) q.dz = 0;
        if ($urandom_range(0, 9) != 0) q.reach = 24'($urandom_range(0, 48 * 256));
        return q;
    endfunction

    // result side: check and stall
    always @(posedge aclk) begin
        voxel_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $error("result with no request pending: status %0d", m_status);
                errors++;
            end else begin
                e = expected_q.pop_front();
                case (e.status)
                    ST_QUERY: n_query++;
                    ST_HIT:   n_hit++;
                    ST_MISS:  n_miss++;
                    default:  n_noreq++;
                endcase
                if (m_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_status); errors++;
                end
                if (m_voxel_x !== e.vx) begin
                    $error("voxel_x: expected %0h, got %0h", e.vx, m_voxel_x); errors++;
                end
                if (m_voxel_y !== e.vy) begin
                    $error("voxel_y: expected %0h, got %0h", e.vy, m_voxel_y); errors++;
                end
                if (m_voxel_z !== e.vz) begin
                    $error("voxel_z: expected %0h, got %0h", e.vz, m_voxel_z); errors++;
                end
                if (m_chunk_index !== e.chunk) begin
                    $error("chunk_index: expected %0d, got %0d", e.chunk, m_chunk_index);
                    errors++;
                end
                if (m_in_chunk_x !== e.ix) begin
                    $error("in_chunk_x: expected %0d, got %0d", e.ix, m_in_chunk_x); errors++;
                end
                if (m_in_chunk_y !== e.iy) begin
                    $error("in_chunk_y: expected %0d, got %0d", e.iy, m_in_chunk_y); errors++;
                end
                if (m_in_chunk_z !== e.iz) begin
                    $error("in_chunk_z: expected %0d, got %0d", e.iz, m_in_chunk_z); errors++;
                end
                if (m_face !== e.face) begin
                    $error("face: expected %0d, got %0d", e.face, m_face); errors++;
                end
            end
        end
        m_ready <= aresetn && ($urandom_range(0, 99) >= recv_stall);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        request_t dir_rows [$];
        request_t q;
        int idle_mix [4][2] = '{'{0, 0}, '{47, 0}, '{0, 47}, '{6, 6}};

        for (int a = 0; a < 3; a++) begin
            win_org[a] = 0;
            win_size[a] = 8;
            vox_pos[a] = 0;
            neg_step[a] = 0;
            bound_d[a] = 0;
            unit_d[a] = 0;
        end
        ray_busy = 0;
        travelled = 0;
        reach_lim = 0;
        last_face = 0;
        steps = 0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reply while idle, axis-aligned rays, ties, extremes
        q = mk(OP_REPLY, 0, 0, 0, 0, 0, 0, 0, 1);
        q.typed = 1; q.typed_status = ST_NOREQ;
        dir_rows.push_back(q);
        dir_rows.push_back(mk(OP_START, 32'h580, 32'h580, 32'h580, 16'h4000, 0, 0,
                              24'h1000, 0));
        dir_rows.push_back(mk(OP_REPLY, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(OP_REPLY, 0, 0, 0, 0, 0, 0, 0, 1));
        dir_rows.push_back(mk(OP_START, 32'h2000, 32'h580, 32'h580, 16'hC000, 0, 0,
                              24'h1000, 0));
        dir_rows.push_back(mk(OP_REPLY, 0, 0, 0, 0, 0, 0, 0, 1));
        dir_rows.push_back(mk(OP_START, 32'h580, 32'h2000, 32'h580, 0, 16'hC000, 0,
                              24'h1000, 0));
        dir_rows.push_back(mk(OP_START, 32'h580, 32'h580, 32'h580, 0, 0, 16'h4000,
                              24'h1000, 0));   // start while busy
        dir_rows.push_back(mk(OP_REPLY, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(OP_START, 32'h500, 32'h500, 32'h500, 16'h2000, 16'h2000, 0,
                              24'h800, 0));    // x/y tie
        dir_rows.push_back(mk(OP_REPLY, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(OP_START, 32'h500, 32'h500, 32'h500, 16'h2000, 16'h2000,
                              16'h2000, 24'hFFFFFF, 0));   // three-way tie
        dir_rows.push_back(mk(OP_REPLY, 0, 0, 0, 0, 0, 0, 0, 0));
        q = mk(OP_START, 32'h580, 32'h580, 32'h580, 0, 0, 0, 24'hFFFFFF, 0);
        q.typed = 1; q.typed_status = ST_MISS;
        dir_rows.push_back(q);
        dir_rows.push_back(mk(OP_START, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                              16'h8000, 16'h7FFF, 16'h8000, 24'hFFFFFF, 0));
        dir_rows.push_back(mk(OP_START, 32'h0, 32'h0, 32'h0, 16'h8000, 16'h8000,
                              16'h8000, 24'h0, 0));
        dir_rows.push_back(mk(OP_START, 32'h7FF, 32'h7FF, 32'h7FF, 16'h7FFF, 16'h0001,
                              16'hFFFF, 24'hFFFFFF, 0));
        dir_rows.push_back(mk(OP_REPLY, 0, 0, 0, 0, 0, 0, 0, 1));
        foreach (dir_rows[i]) send_request(dir_rows[i]);
        drain();

        // random walks; window settings include extremes, clamping and empty
        for (int p = 0; p < 8; p++) begin
            int n_items;
            case (p)
                0: set_window(16'd0, 16'd0, 16'd0, 6'd8, 6'd8, 6'd8);
                1: set_window(16'h8000, 16'h7FFF, 16'hFFFF, 6'd32, 6'd1, 6'd3);
                2: set_window(16'h7FFF, 16'h8000, 16'h0005, 6'd1, 6'd32, 6'd63);
                3: set_window(16'hFFFE, 16'h0003, 16'h8000, 6'd5, 6'd7, 6'd2);
                4: set_window(16'd0, 16'd0, 16'd0, 6'd0, 6'd4, 6'd4);
                5: set_window(16'h0010, 16'hFFF0, 16'h0001, 6'd32, 6'd32, 6'd32);
                6: set_window(16'h0000, 16'h0000, 16'h0000, 6'd1, 6'd1, 6'd1);
                default: set_window(16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd2, 6'd2, 6'd2);
            endcase
            send_idle = idle_mix[p % 4][0];
            recv_stall = idle_mix[p % 4][1];
            n_items = (p == 4) ? 10 : 75;
            for (int i = 0; i < n_items; i++) begin
                send_request(random_request());
                if (i % 40 == 39) drain();
            end
            drain();
        end

        $display("covered %0d requests: %0d queries, %0d hits, %0d misses, %0d stray replies",
                 n_req, n_query, n_hit, n_miss, n_noreq);
        $display("eight window settings, four idle/stall mixes, %0d errors", errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
